// File: rtl/move_to_front_ranker_unit_assert.svh
// assertion helpers for the checker file mtfr_checker.sv
`ifndef MOVE_TO_FRONT_RANKER_UNIT_ASSERT_SVH
`define MOVE_TO_FRONT_RANKER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define MTFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define MTFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mtfr_pkg.sv
`default_nettype none

package mtfr_pkg;

    localparam int DEFAULT_MAX_ITEMS = 256;
    localparam int ITEM_W            = 8;
    localparam int RANK_W            = 8;
    localparam int CFG_W             = 9;
    localparam int RESET_COUNT       = 256;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } mtfr_state_t;

endpackage

`default_nettype wire

// File: rtl/move_to_front_ranker_unit.sv
// Move-to-front ranker. Each request carries an item id; the result gives the
// number of ids ahead of it in the list (rank) and then moves the id to the
// front. Ids at or above num_items give bad_item with rank 0 and leave the list
// alone. The list is a row of MAX_ITEMS cells; a search token walks down it one
// cell per cycle, shifting the ids it passes. A new request is accepted only
// once the last one's result has moved to the output register; a bad one skips
// the search, so the rate is set by the token's walk down the cell chain. One
// request is in work at a time; a finished result may wait in the output
// register while the next request is searched. Reset and every write of
// num_items (clamped to 1..min(MAX_ITEMS, 511)) restore identity order; cfg_ready
// is always high and writes must be made while idle.
`default_nettype none

module move_to_front_ranker_unit #(
    parameter int MAX_ITEMS = mtfr_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [mtfr_pkg::ITEM_W-1:0] item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [mtfr_pkg::RANK_W-1:0]     rank,
    output logic                            bad_item,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mtfr_pkg::CFG_W-1:0] cfg_data
);

    localparam int ID_W      = $clog2(MAX_ITEMS);
    localparam int RST_COUNT = (MAX_ITEMS < mtfr_pkg::RESET_COUNT) ?
                               MAX_ITEMS : mtfr_pkg::RESET_COUNT;

    mtfr_pkg::mtfr_state_t state_reg;
    mtfr_pkg::mtfr_state_t state_next;

    logic [mtfr_pkg::CFG_W-1:0]  num_items_reg;
    logic [mtfr_pkg::CFG_W-1:0]  num_items_next;
    logic [ID_W-1:0]             key_reg;
    logic [ID_W-1:0]             key_next;
    logic                        start_reg;
    logic                        start_next;
    logic [mtfr_pkg::RANK_W-1:0] cnt_reg;
    logic [mtfr_pkg::RANK_W-1:0] cnt_next;
    logic [mtfr_pkg::RANK_W-1:0] res_rank_reg;
    logic [mtfr_pkg::RANK_W-1:0] res_rank_next;
    logic                        res_bad_reg;
    logic                        res_bad_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [mtfr_pkg::RANK_W-1:0] out_rank_reg;
    logic [mtfr_pkg::RANK_W-1:0] out_rank_next;
    logic                        out_bad_reg;
    logic                        out_bad_next;

    logic                        cfg_write;
    logic                        item_acc;
    logic                        item_bad;
    logic                        slot_free;
    logic                        out_load;
    logic                        hit_any;
    logic                        run_off;

    logic [MAX_ITEMS:0]          tok_chain;
    logic [ID_W-1:0]             carry_chain [MAX_ITEMS+1];
    logic [MAX_ITEMS-1:0]        hit_vec;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign item_acc     = item_valid && !item_stall;
    assign item_bad     = {1'b0, item} >= num_items_reg;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign hit_any      = |hit_vec;
    assign run_off      = tok_chain[MAX_ITEMS];
    assign tok_chain[0] = start_reg;
    assign carry_chain[0] = key_reg;

    assign result_valid = out_valid_reg;
    assign rank         = out_rank_reg;
    assign bad_item     = out_bad_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            mtfr_cell #(
                .ID_W  (ID_W),
                .INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .init      (cfg_write),
                .tok_in    (tok_chain[gi]),
                .carry_in  (carry_chain[gi]),
                .key       (key_reg),
                .tok_out   (tok_chain[gi+1]),
                .carry_out (carry_chain[gi+1]),
                .hit       (hit_vec[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtfr_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next = item_bad ? mtfr_pkg::ST_DONE : mtfr_pkg::ST_SEARCH;
                end
            end
            mtfr_pkg::ST_SEARCH:
            begin
                if (hit_any || run_off)
                begin
                    state_next = mtfr_pkg::ST_DONE;
                end
            end
            mtfr_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = mtfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtfr_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            mtfr_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            mtfr_pkg::ST_SEARCH:
            begin
                item_stall = 1'b1;
            end
            mtfr_pkg::ST_DONE:
            begin
                out_load = slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        key_next      = key_reg;
        start_next    = 1'b0;
        cnt_next      = cnt_reg;
        res_rank_next = res_rank_reg;
        res_bad_next  = res_bad_reg;

        if (item_acc)
        begin
            key_next      = ID_W'(item);
            start_next    = !item_bad;
            cnt_next      = '0;
            res_rank_next = '0;
            res_bad_next  = item_bad;
        end
        else if (state_reg == mtfr_pkg::ST_SEARCH)
        begin
            if (hit_any)
            begin
                res_rank_next = cnt_reg;
                res_bad_next  = 1'b0;
            end
            else if (run_off)
            begin
                res_rank_next = '0;
                res_bad_next  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        out_rank_next = out_rank_reg;
        out_bad_next  = out_bad_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rank_next  = res_rank_reg;
            out_bad_next   = res_bad_reg;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        num_items_next = num_items_reg;
        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                num_items_next = mtfr_pkg::CFG_W'(1);
            end
            else if (int'(cfg_data) > MAX_ITEMS)
            begin
                num_items_next = mtfr_pkg::CFG_W'(MAX_ITEMS);
            end
            else
            begin
                num_items_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtfr_pkg::ST_IDLE;
            num_items_reg <= mtfr_pkg::CFG_W'(RST_COUNT);
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_items_reg <= num_items_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        cnt_reg      <= cnt_next;
        res_rank_reg <= res_rank_next;
        res_bad_reg  <= res_bad_next;
        out_rank_reg <= out_rank_next;
        out_bad_reg  <= out_bad_next;
    end

endmodule

`default_nettype wire

// File: rtl/mtfr_cell.sv
`default_nettype none

// one list position: holds an id, swaps with the passing carry until the key is met
module mtfr_cell #(
    parameter int ID_W  = 8,
    parameter int INDEX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            init,
    input  wire logic            tok_in,
    input  wire logic [ID_W-1:0] carry_in,
    input  wire logic [ID_W-1:0] key,
    output logic                 tok_out,
    output logic [ID_W-1:0]      carry_out,
    output logic                 hit
);

    logic [ID_W-1:0] value_reg;
    logic [ID_W-1:0] value_next;
    logic            tok_reg;
    logic            tok_next;
    logic [ID_W-1:0] carry_reg;
    logic [ID_W-1:0] carry_next;

    assign hit       = tok_in && (value_reg == key);
    assign tok_out   = tok_reg;
    assign carry_out = carry_reg;

    always_comb
    begin
        value_next = value_reg;
        tok_next   = 1'b0;
        carry_next = carry_reg;
        if (init)
        begin
            value_next = ID_W'(INDEX);
        end
        else if (tok_in)
        begin
            // take the displaced id from above, pass ours down on a miss
            value_next = carry_in;
            if (!hit)
            begin
                tok_next   = 1'b1;
                carry_next = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= ID_W'(INDEX);
            tok_reg   <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

endmodule

`default_nettype wire

// File: rtl/mtfr_checker.sv
`default_nettype none

`include "move_to_front_ranker_unit_assert.svh"

module mtfr_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire logic                        item_stall,
    input  wire logic                        result_valid,
    input  wire logic                        result_stall,
    input  wire logic [mtfr_pkg::RANK_W-1:0] rank,
    input  wire logic                        bad_item
);

    // a rejected id always reports rank zero
    `MTFR_ASSERT_IMPLY(a_bad_rank_zero, clk, rst_n, result_valid && bad_item, rank == '0, "bad_item with nonzero rank")

    // one request in work at a time
    `MTFR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall, "request accepted while a search is running")

    // a new result only follows a cycle in which requests were held off
    `MTFR_ASSERT_IMPLY(a_result_after_work, clk, rst_n, $rose(result_valid), $past(item_stall), "result appeared without a request in work")

    // a stalled result holds
    `MTFR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(rank) && $stable(bad_item), "stalled result changed")

endmodule

bind move_to_front_ranker_unit mtfr_checker u_mtfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rank         (rank),
    .bad_item     (bad_item)
);

`default_nettype wire
